// File: hdl/flash_ecc_diag_registers_unit_macros.svh
// Assertion helpers shared by the flash diagnostic register block.
// Both sample on clk and are silent while rst is high.
`ifndef FLASH_ECC_DIAG_REGISTERS_UNIT_MACROS_SVH
`define FLASH_ECC_DIAG_REGISTERS_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FEDR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FEDR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fedr_pkg.sv
package fedr_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } fedr_state_t;

  // Flash controller map, word offsets.
  localparam logic [9:0] OFF_PA_STATUS   = 10'd5;
  localparam logic [9:0] OFF_PB_STATUS   = 10'd6;
  localparam logic [9:0] OFF_PRIM_TAG    = 10'd10;
  localparam logic [9:0] OFF_DUP_TAG     = 10'd11;
  localparam logic [9:0] OFF_EMU_ECC     = 10'd24;
  localparam logic [9:0] OFF_DIAG_CTRL   = 10'd27;
  localparam logic [9:0] OFF_RAW_ADDR    = 10'd29;

  // CAM map, word offsets.
  localparam logic [9:0] OFF_CAM_AVAIL   = 10'd6;
  localparam logic [9:0] OFF_CAM_CONTENT = 10'd40;
  localparam logic [9:0] OFF_CAM_INDEX   = 10'd128;

  localparam int unsigned TRIGGER_POS = 24;
  localparam logic [31:0] PAR_ERR_BIT  = 32'h0000_0400;
  localparam logic [31:0] TAG_ERR_BIT  = 32'h0000_0800;
  localparam logic [3:0]  DIAG_KEY     = 4'h5;
  localparam logic [2:0]  MODE_ADDRESS = 3'h5;
  localparam logic [31:0] ECC_SINGLE_BIT = 32'h0000_00CE;

  // Buffer select codes.
  localparam logic [2:0] BUF_SEL_A_LAST    = 3'd1;
  localparam logic [2:0] BUF_SEL_SKIP_LO   = 3'd2;
  localparam logic [2:0] BUF_SEL_SKIP_HI   = 3'd3;

  localparam logic [31:0] SBE_ADDR_RESET = 32'h0000_0008;

endpackage

// File: hdl/flash_ecc_diag_registers_unit.sv
// Diagnostic register block of a flash controller with an error-position CAM.
// Bus accesses arrive on the input channel (in_valid/in_ready) as command,
// region, word_offset and write_data; each access gives exactly one result
// transaction on the output channel (out_valid/out_ready) carrying read_data
// and the three interrupt-raise flags.
// Throughput: one transaction per cycle is sustained for register accesses and
// all writes while the receiver keeps up. A read of a CAM content or index word
// passes through the registered read port of the CAM memory and then through
// the output register, and no new access is taken meanwhile. Other results are
// registered in the cycle after acceptance.
// A single output register holds the result; a new access is taken in the
// same cycle that a waiting result is taken. While the receiver stalls, the
// result holds and no new access is accepted.
// Reset (rst, synchronous) clears the state, the diagnostic registers and the
// CAM valid bits, and presets the error address; no clearing pass is needed.
// The single-bit error address is written over the APB port at addresses 0 to 3.
module flash_ecc_diag_registers_unit #(
  parameter int CAM_ENTRIES     = 32,
  parameter int CAM_INDEX_WORDS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic        region,
  input  logic [9:0]  word_offset,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_data,
  output logic        raise_uncorrectable,
  output logic        raise_bus_fault,
  output logic        raise_correctable
);
  import fedr_pkg::*;

  localparam int MEM_DEPTH = CAM_ENTRIES + CAM_INDEX_WORDS;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam logic [10:0] CONT_LO = 11'(OFF_CAM_CONTENT);
  localparam logic [10:0] CONT_HI = 11'(int'(OFF_CAM_CONTENT) + CAM_ENTRIES);
  localparam logic [10:0] IDX_LO  = 11'(OFF_CAM_INDEX);
  localparam logic [10:0] IDX_HI  = 11'(int'(OFF_CAM_INDEX) + CAM_INDEX_WORDS);
  localparam logic [MEM_AW-1:0] IDX_BASE = MEM_AW'(CAM_ENTRIES);

  fedr_state_t state, state_next;

  logic [31:0] sbe_addr;
  logic [31:0] diag_control, diag_control_next;
  logic [31:0] raw_address, raw_address_next;
  logic [31:0] primary_tag, primary_tag_next;
  logic [31:0] duplicate_tag, duplicate_tag_next;
  logic [31:0] port_a_status, port_a_status_next;
  logic [31:0] port_b_status, port_b_status_next;
  logic [31:0] emulated_ecc, emulated_ecc_next;
  logic        cam_available, cam_available_next;

  logic [31:0]          cam_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] cam_valid;
  logic [31:0]          mem_rdata;
  logic                 mem_rvalid;

  logic              acc;
  logic              in_cont, in_cidx, mem_hit, mem_read;
  logic [9:0]        cont_ofs, cidx_ofs;
  logic [MEM_AW-1:0] mem_addr, mem_wa;
  logic              mem_we;
  logic [31:0]       mem_wd;

  logic        flash_wr, diag_wr;
  logic        trig, tag_mode, sel_skip, inject, inj_corr;
  logic [2:0]  buf_sel;
  logic [31:0] err_bit;
  logic        irq_unc, irq_bus, irq_cor;
  logic [31:0] rd_direct;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'h0 : sbe_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      sbe_addr <= SBE_ADDR_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      sbe_addr <= pwdata;
    end
  end

  // Decode.
  assign acc      = in_valid && in_ready;
  assign in_cont  = region && ({1'b0, word_offset} >= CONT_LO)
                           && ({1'b0, word_offset} < CONT_HI);
  assign in_cidx  = region && ({1'b0, word_offset} >= IDX_LO)
                           && ({1'b0, word_offset} < IDX_HI);
  assign mem_hit  = in_cont || in_cidx;
  assign mem_read = !command && mem_hit;
  assign cont_ofs = word_offset - OFF_CAM_CONTENT;
  assign cidx_ofs = word_offset - OFF_CAM_INDEX;
  assign mem_addr = in_cont ? cont_ofs[MEM_AW-1:0] : IDX_BASE + cidx_ofs[MEM_AW-1:0];

  assign flash_wr = acc && command && !region;
  assign diag_wr  = flash_wr && (word_offset == OFF_DIAG_CTRL);

  assign trig     = write_data[TRIGGER_POS] && (write_data[19:16] == DIAG_KEY);
  assign tag_mode = (write_data[2:0] == MODE_ADDRESS);
  assign buf_sel  = write_data[10:8];
  assign sel_skip = buf_sel inside {[BUF_SEL_SKIP_LO:BUF_SEL_SKIP_HI]};
  assign err_bit  = tag_mode ? TAG_ERR_BIT : PAR_ERR_BIT;
  assign inj_corr = diag_wr && trig && !tag_mode && (emulated_ecc == ECC_SINGLE_BIT);
  // An injection that reaches a port updates status and raises its interrupt.
  assign inject   = diag_wr && trig && !sel_skip;
  assign irq_unc  = inject && tag_mode;
  assign irq_cor  = inject && !tag_mode && (emulated_ecc == ECC_SINGLE_BIT);
  assign irq_bus  = inject && !tag_mode && (emulated_ecc != ECC_SINGLE_BIT);

  // The CAM memory has one write port, used either by a bus write to the CAM
  // map or by a correctable injection loading entry zero.
  assign mem_we = (acc && command && region && mem_hit) || inj_corr;
  assign mem_wa = region ? mem_addr : '0;
  assign mem_wd = region ? write_data : sbe_addr;

  always_comb begin
    diag_control_next  = diag_control;
    raw_address_next   = raw_address;
    primary_tag_next   = primary_tag;
    duplicate_tag_next = duplicate_tag;
    port_a_status_next = port_a_status;
    port_b_status_next = port_b_status;
    emulated_ecc_next  = emulated_ecc;
    cam_available_next = cam_available;
    if (flash_wr) begin
      case (word_offset)
        OFF_DIAG_CTRL: begin
          diag_control_next = write_data;
          if (inject) begin
            diag_control_next[TRIGGER_POS] = 1'b0;
            if (buf_sel <= BUF_SEL_A_LAST) begin
              port_a_status_next = port_a_status | err_bit;
            end else begin
              port_b_status_next = port_b_status | err_bit;
            end
          end
        end
        OFF_RAW_ADDR:  raw_address_next   = write_data;
        OFF_PRIM_TAG:  primary_tag_next   = write_data;
        OFF_DUP_TAG:   duplicate_tag_next = write_data;
        OFF_PA_STATUS: port_a_status_next = port_a_status & ~write_data;
        OFF_PB_STATUS: port_b_status_next = port_b_status & ~write_data;
        OFF_EMU_ECC:   emulated_ecc_next  = write_data;
        default: ;
      endcase
    end
    if (inj_corr) begin
      cam_available_next = 1'b1;
    end
    if (acc && command && in_cidx) begin
      cam_available_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diag_control  <= '0;
      raw_address   <= '0;
      primary_tag   <= '0;
      duplicate_tag <= '0;
      port_a_status <= '0;
      port_b_status <= '0;
      emulated_ecc  <= '0;
      cam_available <= 1'b0;
    end else begin
      diag_control  <= diag_control_next;
      raw_address   <= raw_address_next;
      primary_tag   <= primary_tag_next;
      duplicate_tag <= duplicate_tag_next;
      port_a_status <= port_a_status_next;
      port_b_status <= port_b_status_next;
      emulated_ecc  <= emulated_ecc_next;
      cam_available <= cam_available_next;
    end
  end

  // CAM memory with registered read. Reads happen only at acceptance and the
  // block takes nothing while the data is in flight, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cam_mem[mem_wa] <= mem_wd;
    end
    if (acc && mem_read) begin
      mem_rdata  <= cam_mem[mem_addr];
      mem_rvalid <= cam_valid[mem_addr];
    end
  end

  // An entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_valid <= '0;
    end else if (mem_we) begin
      cam_valid[mem_wa] <= 1'b1;
    end
  end

  always_comb begin
    rd_direct = 32'h0;
    if (!command) begin
      if (region) begin
        if (word_offset == OFF_CAM_AVAIL) begin
          rd_direct = {31'h0, cam_available};
        end
      end else begin
        case (word_offset)
          OFF_DIAG_CTRL: rd_direct = diag_control;
          OFF_RAW_ADDR:  rd_direct = raw_address;
          OFF_PRIM_TAG:  rd_direct = primary_tag;
          OFF_DUP_TAG:   rd_direct = duplicate_tag;
          OFF_PA_STATUS: rd_direct = port_a_status;
          OFF_PB_STATUS: rd_direct = port_b_status;
          default:       rd_direct = 32'h0;
        endcase
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (acc && mem_read) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_READ) begin
      out_valid <= 1'b1;
    end else if (acc && !mem_read) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      read_data           <= mem_rvalid ? mem_rdata : 32'h0;
      raise_uncorrectable <= 1'b0;
      raise_bus_fault     <= 1'b0;
      raise_correctable   <= 1'b0;
    end else if (acc && !mem_read) begin
      read_data           <= rd_direct;
      raise_uncorrectable <= irq_unc;
      raise_bus_fault     <= irq_bus;
      raise_correctable   <= irq_cor;
    end
  end

`include "flash_ecc_diag_registers_unit_macros.svh"

  `FEDR_ASSERT_NOW(a_one_irq, out_valid, $countones({raise_uncorrectable, raise_bus_fault, raise_correctable}) <= 1, "more than one interrupt raised by one transaction")
  `FEDR_ASSERT_NOW(a_read_slot_free, state == ST_READ, !out_valid, "CAM read data arrived while the output register was occupied")
  `FEDR_ASSERT_NEXT(a_write_result, in_valid && in_ready && command, out_valid && (read_data == 32'h0), "write transaction did not give a zero result in the next cycle")
  `FEDR_ASSERT_NEXT(a_cam_read_wait, in_valid && in_ready && !command && mem_hit, state == ST_READ && !in_ready, "CAM word read did not wait for the memory")

endmodule

// File: tb/flash_ecc_diag_registers_unit_tb.sv
module flash_ecc_diag_registers_unit_tb;
  import fedr_pkg::*;

  localparam int CAM_ENTRIES     = 32;
  localparam int CAM_INDEX_WORDS = 8;
  localparam int CW_AW           = $clog2(CAM_ENTRIES);
  localparam int CI_AW           = $clog2(CAM_INDEX_WORDS);

  localparam bit CMD_READ     = 1'b0;
  localparam bit CMD_WRITE    = 1'b1;
  localparam bit REGION_FLASH = 1'b0;
  localparam bit REGION_CAM   = 1'b1;

  localparam logic [2:0] APB_SBE_ADDR = 3'd0;
  localparam logic [9:0] OFF_NO_EFFECT = 10'd22;
  localparam logic [9:0] OFF_CONT_LAST = 10'(int'(OFF_CAM_CONTENT) + CAM_ENTRIES - 1);
  localparam logic [9:0] OFF_CONT_PAST = 10'(int'(OFF_CAM_CONTENT) + CAM_ENTRIES);
  localparam logic [9:0] OFF_IDX_LAST  = 10'(int'(OFF_CAM_INDEX) + CAM_INDEX_WORDS - 1);

  localparam int PHASE_ITEMS    = 616;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {
    IRQ_NONE,
    IRQ_UNCORRECTABLE,
    IRQ_BUS_FAULT,
    IRQ_CORRECTABLE
  } irq_kind_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        uncorrectable;
    logic        bus_fault;
    logic        correctable;
  } access_result_t;

  typedef struct {
    bit             cmd;
    bit             rgn;
    logic [9:0]     off;
    logic [31:0]    data;
    bit             typed;
    access_result_t exp;
  } access_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = 1'b0;
  logic        region = 1'b0;
  logic [9:0]  word_offset = '0;
  logic [31:0] write_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_data;
  logic        raise_uncorrectable;
  logic        raise_bus_fault;
  logic        raise_correctable;

  flash_ecc_diag_registers_unit #(
    .CAM_ENTRIES    (CAM_ENTRIES),
    .CAM_INDEX_WORDS(CAM_INDEX_WORDS)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .command            (command),
    .region             (region),
    .word_offset        (word_offset),
    .write_data         (write_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .read_data          (read_data),
    .raise_uncorrectable(raise_uncorrectable),
    .raise_bus_fault    (raise_bus_fault),
    .raise_correctable  (raise_correctable)
  );

  always #5 clk = ~clk;

  // Shadow copy of the register block.
  logic [31:0] shadow_sbe_addr = SBE_ADDR_RESET;
  logic [31:0] shadow_diag_ctrl = '0;
  logic [31:0] shadow_raw_addr = '0;
  logic [31:0] shadow_prim_tag = '0;
  logic [31:0] shadow_dup_tag = '0;
  logic [31:0] shadow_pa_status = '0;
  logic [31:0] shadow_pb_status = '0;
  logic [31:0] shadow_emu_ecc = '0;
  logic        shadow_cam_avail = 1'b0;
  logic [31:0] shadow_cam_words [CAM_ENTRIES];
  logic [31:0] shadow_cam_index [CAM_INDEX_WORDS];

  access_result_t expected_results [$];

  bit             in_take;
  bit             out_take;
  bit             cur_typed;
  access_result_t cur_exp;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             hold_req;
  int             errors;
  int             idle_cycles;
  int             n_reads;
  int             n_writes;
  int             n_uncorr;
  int             n_bus;
  int             n_corr;

  function automatic access_result_t make_result(logic [31:0] rd, irq_kind_t irq);
    access_result_t r;
    r.read_data     = rd;
    r.uncorrectable = (irq == IRQ_UNCORRECTABLE);
    r.bus_fault     = (irq == IRQ_BUS_FAULT);
    r.correctable   = (irq == IRQ_CORRECTABLE);
    return r;
  endfunction

  function automatic irq_kind_t inject_from_diag(logic [31:0] v);
    logic [31:0] err_bit;
    logic [2:0]  sel;
    irq_kind_t   irq;
    shadow_diag_ctrl = v;
    if (!v[TRIGGER_POS] || v[19:16] != DIAG_KEY) return IRQ_NONE;
    if (v[2:0] == MODE_ADDRESS) begin
      err_bit = TAG_ERR_BIT;
      irq = IRQ_UNCORRECTABLE;
    end else begin
      err_bit = PAR_ERR_BIT;
      if (shadow_emu_ecc == ECC_SINGLE_BIT) begin
        irq = IRQ_CORRECTABLE;
        shadow_cam_avail = 1'b1;
        shadow_cam_words[0] = shadow_sbe_addr;
      end else begin
        irq = IRQ_BUS_FAULT;
      end
    end
    sel = v[10:8];
    // The two middle buffer selects leave the trigger armed and raise nothing.
    if (sel == BUF_SEL_SKIP_LO || sel == BUF_SEL_SKIP_HI) return IRQ_NONE;
    if (sel <= BUF_SEL_A_LAST) shadow_pa_status |= err_bit;
    else shadow_pb_status |= err_bit;
    shadow_diag_ctrl[TRIGGER_POS] = 1'b0;
    return irq;
  endfunction

  function automatic access_result_t predict_access(bit cmd, bit rgn, logic [9:0] off,
                                                     logic [31:0] data);
    logic [31:0] rd;
    irq_kind_t   irq;
    bit          in_content;
    bit          in_index;
    rd = '0;
    irq = IRQ_NONE;
    in_content = (off >= OFF_CAM_CONTENT) && (off < OFF_CAM_CONTENT + CAM_ENTRIES);
    in_index = (off >= OFF_CAM_INDEX) && (off < OFF_CAM_INDEX + CAM_INDEX_WORDS);
    if (cmd == CMD_WRITE && rgn == REGION_CAM) begin
      if (in_content) begin
        shadow_cam_words[CW_AW'(off - OFF_CAM_CONTENT)] = data;
      end else if (in_index) begin
        shadow_cam_index[CI_AW'(off - OFF_CAM_INDEX)] = data;
        shadow_cam_avail = 1'b0;
      end
    end else if (cmd == CMD_WRITE) begin
      case (off)
        OFF_DIAG_CTRL: irq = inject_from_diag(data);
        OFF_RAW_ADDR:  shadow_raw_addr = data;
        OFF_PRIM_TAG:  shadow_prim_tag = data;
        OFF_DUP_TAG:   shadow_dup_tag = data;
        OFF_PA_STATUS: shadow_pa_status &= ~data;
        OFF_PB_STATUS: shadow_pb_status &= ~data;
        OFF_EMU_ECC:   shadow_emu_ecc = data;
        default: ;
      endcase
    end else if (rgn == REGION_CAM) begin
      if (off == OFF_CAM_AVAIL) rd = {31'd0, shadow_cam_avail};
      else if (in_content) rd = shadow_cam_words[CW_AW'(off - OFF_CAM_CONTENT)];
      else if (in_index) rd = shadow_cam_index[CI_AW'(off - OFF_CAM_INDEX)];
    end else begin
      case (off)
        OFF_DIAG_CTRL: rd = shadow_diag_ctrl;
        OFF_RAW_ADDR:  rd = shadow_raw_addr;
        OFF_PRIM_TAG:  rd = shadow_prim_tag;
        OFF_DUP_TAG:   rd = shadow_dup_tag;
        OFF_PA_STATUS: rd = shadow_pa_status;
        OFF_PB_STATUS: rd = shadow_pb_status;
        default: ;
      endcase
    end
    return make_result(rd, irq);
  endfunction

  // Handshakes are judged on the falling edge, before the next rising edge, when nothing is moving.
  always @(negedge clk) begin
    access_result_t predicted;
    access_result_t want;
    in_take = !rst && in_valid && in_ready;
    out_take = !rst && out_valid && out_ready;
    if (out_take) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: read_data %h", read_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, read_data);
          errors++;
        end
        if (raise_uncorrectable !== want.uncorrectable) begin
          $error("raise_uncorrectable: expected %b, got %b", want.uncorrectable,
                 raise_uncorrectable);
          errors++;
        end
        if (raise_bus_fault !== want.bus_fault) begin
          $error("raise_bus_fault: expected %b, got %b", want.bus_fault, raise_bus_fault);
          errors++;
        end
        if (raise_correctable !== want.correctable) begin
          $error("raise_correctable: expected %b, got %b", want.correctable,
                 raise_correctable);
          errors++;
        end
      end
    end
    if (in_take) begin
      predicted = predict_access(command, region, word_offset, write_data);
      expected_results.push_back(cur_typed ? cur_exp : predicted);
      if (command == CMD_WRITE) n_writes++;
      else n_reads++;
      n_uncorr += int'(predicted.uncorrectable);
      n_bus += int'(predicted.bus_fault);
      n_corr += int'(predicted.correctable);
    end
    if (!rst) begin
      if (in_take || out_take) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    int hold_left;
    int hold_seen;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_access(access_row_t row);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(3, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= row.cmd;
    region <= row.rgn;
    word_offset <= row.off;
    write_data <= row.data;
    cur_typed = row.typed;
    cur_exp = row.exp;
    do @(posedge clk); while (!in_take);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic set_error_address(logic [31:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_SBE_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_sbe_addr = value;
  endtask

  function automatic access_row_t make_row(bit cmd, bit rgn, logic [9:0] off,
                                           logic [31:0] data, bit typed,
                                           logic [31:0] rd, irq_kind_t irq);
    access_row_t row;
    row.cmd = cmd;
    row.rgn = rgn;
    row.off = off;
    row.data = data;
    row.typed = typed;
    row.exp = make_result(rd, irq);
    return row;
  endfunction

  // Mostly mapped offsets, with injection writes shaped to pass the key check.
  function automatic access_row_t make_random_access();
    access_row_t row;
    row.cmd = 1'($urandom_range(1));
    row.rgn = 1'($urandom_range(1));
    row.data = $urandom;
    row.typed = 1'b0;
    row.exp = '0;
    if ($urandom_range(99) < 15) begin
      row.off = 10'($urandom_range(1023));
    end else if (row.rgn == REGION_FLASH) begin
      case ($urandom_range(9))
        0: row.off = OFF_PA_STATUS;
        1: row.off = OFF_PB_STATUS;
        2: row.off = OFF_PRIM_TAG;
        3: row.off = OFF_DUP_TAG;
        4: row.off = OFF_EMU_ECC;
        5: row.off = OFF_RAW_ADDR;
        6: row.off = 10'(int'(OFF_NO_EFFECT) + $urandom_range(1));
        default: row.off = OFF_DIAG_CTRL;
      endcase
    end else begin
      case ($urandom_range(3))
        0: row.off = OFF_CAM_AVAIL;
        3: row.off = 10'(int'(OFF_CAM_INDEX) + $urandom_range(CAM_INDEX_WORDS - 1));
        default: row.off = 10'(int'(OFF_CAM_CONTENT) + $urandom_range(CAM_ENTRIES - 1));
      endcase
    end
    if (row.cmd == CMD_WRITE && row.rgn == REGION_FLASH) begin
      if (row.off == OFF_DIAG_CTRL && $urandom_range(9) < 8) begin
        row.data[TRIGGER_POS] = 1'b1;
        row.data[19:16] = DIAG_KEY;
        if ($urandom_range(1)) row.data[2:0] = MODE_ADDRESS;
      end else if (row.off == OFF_EMU_ECC && $urandom_range(1)) begin
        row.data = ECC_SINGLE_BIT;
      end
    end
    return row;
  endfunction

  task automatic run_phase(int snd_pct, int rcv_pct, bit with_hold, bit with_pause);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (with_hold && i == PHASE_ITEMS / 3) hold_req++;
      if (with_pause && i == PHASE_ITEMS / 2) drain_results();
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      send_access(make_random_access());
    end
  endtask

  initial begin
    access_row_t directed [$];
    for (int i = 0; i < CAM_ENTRIES; i++) shadow_cam_words[i] = '0;
    for (int i = 0; i < CAM_INDEX_WORDS; i++) shadow_cam_index[i] = '0;
    send_idle_pct = 20;
    recv_idle_pct = 20;

    directed.push_back(make_row(CMD_READ, REGION_FLASH, OFF_DIAG_CTRL, '0, 1'b1, '0,
                                IRQ_NONE));
    directed.push_back(make_row(CMD_WRITE, REGION_FLASH, OFF_PRIM_TAG, '1, 1'b1, '0,
                                IRQ_NONE));
    directed.push_back(make_row(CMD_READ, REGION_FLASH, OFF_PRIM_TAG, '0, 1'b1, '1,
                                IRQ_NONE));
    // Address mode on port A: tag error and uncorrectable, trigger cleared.
    directed.push_back(make_row(CMD_WRITE, REGION_FLASH, OFF_DIAG_CTRL, 32'h0105_0005, 1'b1,
                                '0, IRQ_UNCORRECTABLE));
    directed.push_back(make_row(CMD_READ, REGION_FLASH, OFF_PA_STATUS, '0, 1'b1, TAG_ERR_BIT,
                                IRQ_NONE));
    directed.push_back(make_row(CMD_READ, REGION_FLASH, OFF_DIAG_CTRL, '0, 1'b1, 32'h0005_0005,
                                IRQ_NONE));
    // Emulated ECC is write only.
    directed.push_back(make_row(CMD_WRITE, REGION_FLASH, OFF_EMU_ECC, ECC_SINGLE_BIT, 1'b1,
                                '0, IRQ_NONE));
    directed.push_back(make_row(CMD_READ, REGION_FLASH, OFF_EMU_ECC, '0, 1'b1, '0, IRQ_NONE));
    // Correctable on port B loads CAM entry zero with the error address.
    directed.push_back(make_row(CMD_WRITE, REGION_FLASH, OFF_DIAG_CTRL, 32'h0105_0400, 1'b1,
                                '0, IRQ_CORRECTABLE));
    directed.push_back(make_row(CMD_READ, REGION_FLASH, OFF_PB_STATUS, '0, 1'b1, PAR_ERR_BIT,
                                IRQ_NONE));
    directed.push_back(make_row(CMD_READ, REGION_CAM, OFF_CAM_AVAIL, '0, 1'b1, 32'd1,
                                IRQ_NONE));
    directed.push_back(make_row(CMD_READ, REGION_CAM, OFF_CAM_CONTENT, '0, 1'b1,
                                SBE_ADDR_RESET, IRQ_NONE));
    // Skipped buffer select keeps the trigger bit and raises nothing.
    directed.push_back(make_row(CMD_WRITE, REGION_FLASH, OFF_DIAG_CTRL, 32'h0105_0300, 1'b1,
                                '0, IRQ_NONE));
    directed.push_back(make_row(CMD_READ, REGION_FLASH, OFF_DIAG_CTRL, '0, 1'b1, 32'h0105_0300,
                                IRQ_NONE));
    directed.push_back(make_row(CMD_WRITE, REGION_FLASH, OFF_EMU_ECC, '0, 1'b1, '0, IRQ_NONE));
    directed.push_back(make_row(CMD_WRITE, REGION_FLASH, OFF_DIAG_CTRL, 32'hFFF5_FFFE, 1'b1,
                                '0, IRQ_BUS_FAULT));
    directed.push_back(make_row(CMD_WRITE, REGION_FLASH, OFF_PB_STATUS, '1, 1'b1, '0,
                                IRQ_NONE));
    directed.push_back(make_row(CMD_READ, REGION_FLASH, OFF_PB_STATUS, '0, 1'b1, '0,
                                IRQ_NONE));
    // An index word write drops the CAM-available flag.
    directed.push_back(make_row(CMD_WRITE, REGION_CAM, OFF_IDX_LAST, '1, 1'b1, '0, IRQ_NONE));
    directed.push_back(make_row(CMD_READ, REGION_CAM, OFF_CAM_AVAIL, '0, 1'b1, '0, IRQ_NONE));
    directed.push_back(make_row(CMD_WRITE, REGION_CAM, OFF_CONT_LAST, 32'h1234_5678, 1'b0,
                                '0, IRQ_NONE));
    directed.push_back(make_row(CMD_READ, REGION_CAM, OFF_CONT_LAST, '0, 1'b0, '0, IRQ_NONE));
    directed.push_back(make_row(CMD_READ, REGION_FLASH, 10'd1023, '0, 1'b1, '0, IRQ_NONE));
    directed.push_back(make_row(CMD_READ, REGION_CAM, OFF_CONT_PAST, '0, 1'b1, '0, IRQ_NONE));
    directed.push_back(make_row(CMD_WRITE, REGION_FLASH, OFF_NO_EFFECT, '1, 1'b1, '0,
                                IRQ_NONE));
    // Wrong key: stored, but no injection.
    directed.push_back(make_row(CMD_WRITE, REGION_FLASH, OFF_DIAG_CTRL, 32'h0106_0005, 1'b1,
                                '0, IRQ_NONE));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_access(directed[i]);

    set_error_address(32'hFFFF_FFFF);
    run_phase(20, 69, 0, 1);
    set_error_address(32'h0000_0000);
    run_phase(69, 20, 0, 0);
    set_error_address($urandom);
    run_phase(0, 0, 1, 0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d accesses (%0d reads, %0d writes) under three idle patterns and four",
             n_reads + n_writes, n_reads, n_writes);
    $display("error address settings; injections: %0d uncorrectable, %0d bus, %0d correctable.",
             n_uncorr, n_bus, n_corr);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
